/* rtl/core/errm_pkg.sv */
// ----------------------------------------------------------------------------
// errm_pkg
// Shared types and constants for the echo request/reply matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package errm_pkg;

  localparam int PENDING_DEPTH  = 16;
  localparam int ANSWERED_DEPTH = 16;

  localparam int SEQ_W   = 16;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;
  localparam int STAT_W  = 3;

  // Ring pointer width; a single-entry ring still keeps a one-bit pointer.
  localparam int APTR_W = (ANSWERED_DEPTH > 1) ? $clog2(ANSWERED_DEPTH) : 1;

  typedef enum logic [STAT_W-1:0] {
    ST_STORED    = 3'd0,
    ST_FULL      = 3'd1,
    ST_MATCHED   = 3'd2,
    ST_DUP       = 3'd3,
    ST_UNMATCHED = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // register the item and the table lookup
    logic commit;    // update the tables and register the result
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/errm_ctrl.sv */
// ----------------------------------------------------------------------------
// errm_ctrl
// Two-state sequencer: lookup on the accept cycle, table update on the next.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module errm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  output errm_pkg::cmd_t      cmd
);

  errm_pkg::state_t state_r;
  errm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= errm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      errm_pkg::S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = errm_pkg::S_EXEC;
        end
      end
      errm_pkg::S_EXEC: begin
        busy       = 1'b1;
        cmd.commit = 1'b1;
        state_nxt  = errm_pkg::S_IDLE;
      end
      default: begin
        state_nxt = errm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/errm_dp.sv */
// ----------------------------------------------------------------------------
// errm_dp
// Pending table, answered ring, unmatched counter and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module errm_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire errm_pkg::cmd_t                  cmd,
  input  wire logic                            in_func,
  input  wire logic [errm_pkg::SEQ_W-1:0]      in_seq,
  input  wire logic [errm_pkg::TIME_W-1:0]     in_time_us,
  output logic                                 out_valid,
  output logic [errm_pkg::STAT_W-1:0]          out_status,
  output logic [errm_pkg::TIME_W-1:0]          out_rtt_us,
  output logic [errm_pkg::COUNT_W-1:0]         out_unmatched_total
);

  localparam int PD = errm_pkg::PENDING_DEPTH;
  localparam int AD = errm_pkg::ANSWERED_DEPTH;

  // Pending table, kept packed with slot 0 the newest.
  logic [PD-1:0]                      pend_valid_r;
  logic [PD-1:0]                      pend_valid_nxt;
  logic [errm_pkg::SEQ_W-1:0]         pend_seq_r   [PD];
  logic [errm_pkg::SEQ_W-1:0]         pend_seq_nxt [PD];
  logic [errm_pkg::TIME_W-1:0]        pend_time_r  [PD];
  logic [errm_pkg::TIME_W-1:0]        pend_time_nxt[PD];

  // Answered ring.
  logic [AD-1:0]                      ans_valid_r;
  logic [errm_pkg::SEQ_W-1:0]         ans_seq_r[AD];
  logic [errm_pkg::APTR_W-1:0]        ans_wptr_r;
  logic [errm_pkg::APTR_W-1:0]        ans_wptr_nxt;

  logic [errm_pkg::COUNT_W-1:0]       unmatched_cnt_r;
  logic [errm_pkg::COUNT_W-1:0]       unmatched_cnt_nxt;

  // Captured item and lookup results.
  logic                               req_func_r;
  logic [errm_pkg::SEQ_W-1:0]         req_seq_r;
  logic [errm_pkg::TIME_W-1:0]        req_time_r;
  logic [PD-1:0]                      hit_r;
  logic [PD-1:0]                      hit_nxt;
  logic [PD-1:0]                      tail_r;
  logic [PD-1:0]                      tail_nxt;
  logic                               dup_r;
  logic                               dup_nxt;

  logic                               out_valid_r;
  errm_pkg::status_t                  out_status_r;
  errm_pkg::status_t                  status_nxt;
  logic [errm_pkg::TIME_W-1:0]        out_rtt_r;
  logic [errm_pkg::TIME_W-1:0]        rtt_nxt;
  logic [errm_pkg::TIME_W-1:0]        sent_time;
  logic                               hit_any;
  logic                               full;
  logic                               do_insert;
  logic                               do_remove;

  // Lookup on the accept cycle: the tables do not change while idle.
  always_comb begin
    logic found;
    found   = 1'b0;
    hit_nxt = '0;
    dup_nxt = 1'b0;
    for (int i = 0; i < PD; i++) begin
      if (!found && pend_valid_r[i] && (pend_seq_r[i] == in_seq)) begin
        hit_nxt[i] = 1'b1;
        found      = 1'b1;
      end
      // Slots at or behind the hit move up by one on removal.
      tail_nxt[i] = found;
    end
    for (int j = 0; j < AD; j++) begin
      if (ans_valid_r[j] && (ans_seq_r[j] == in_seq)) begin
        dup_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func_r <= in_func;
      req_seq_r  <= in_seq;
      req_time_r <= in_time_us;
      hit_r      <= hit_nxt;
      tail_r     <= tail_nxt;
      dup_r      <= dup_nxt;
    end
  end

  assign hit_any   = |hit_r;
  assign full      = pend_valid_r[PD-1];
  assign do_insert = cmd.commit && !req_func_r && !full;
  assign do_remove = cmd.commit && req_func_r && hit_any;

  always_comb begin
    sent_time = '0;
    for (int i = 0; i < PD; i++) begin
      if (hit_r[i]) begin
        sent_time = sent_time | pend_time_r[i];
      end
    end
  end

  always_comb begin
    rtt_nxt           = '0;
    unmatched_cnt_nxt = unmatched_cnt_r;
    if (!req_func_r) begin
      status_nxt = full ? errm_pkg::ST_FULL : errm_pkg::ST_STORED;
    end else if (hit_any) begin
      status_nxt = errm_pkg::ST_MATCHED;
      rtt_nxt    = req_time_r - sent_time;
    end else if (dup_r) begin
      status_nxt = errm_pkg::ST_DUP;
    end else begin
      status_nxt = errm_pkg::ST_UNMATCHED;
      if (unmatched_cnt_r != '1) begin
        unmatched_cnt_nxt = unmatched_cnt_r + 1'b1;
      end
    end
  end

  // Pending table next state: shift in at slot 0, or close the gap at the hit.
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    for (int i = 0; i < PD; i++) begin
      pend_seq_nxt[i]  = pend_seq_r[i];
      pend_time_nxt[i] = pend_time_r[i];
    end
    if (do_insert) begin
      for (int i = PD - 1; i > 0; i--) begin
        pend_valid_nxt[i] = pend_valid_r[i-1];
        pend_seq_nxt[i]   = pend_seq_r[i-1];
        pend_time_nxt[i]  = pend_time_r[i-1];
      end
      pend_valid_nxt[0] = 1'b1;
      pend_seq_nxt[0]   = req_seq_r;
      pend_time_nxt[0]  = req_time_r;
    end else if (do_remove) begin
      for (int i = 0; i < PD - 1; i++) begin
        if (tail_r[i]) begin
          pend_valid_nxt[i] = pend_valid_r[i+1];
          pend_seq_nxt[i]   = pend_seq_r[i+1];
          pend_time_nxt[i]  = pend_time_r[i+1];
        end
      end
      pend_valid_nxt[PD-1] = 1'b0;
    end
  end

  always_comb begin
    if (ans_wptr_r == errm_pkg::APTR_W'(AD - 1)) begin
      ans_wptr_nxt = '0;
    end else begin
      ans_wptr_nxt = ans_wptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r    <= '0;
      ans_valid_r     <= '0;
      ans_wptr_r      <= '0;
      unmatched_cnt_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.commit) begin
        pend_valid_r    <= pend_valid_nxt;
        unmatched_cnt_r <= unmatched_cnt_nxt;
      end
      if (do_remove) begin
        ans_valid_r[ans_wptr_r] <= 1'b1;
        ans_wptr_r              <= ans_wptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < PD; i++) begin
        pend_seq_r[i]  <= pend_seq_nxt[i];
        pend_time_r[i] <= pend_time_nxt[i];
      end
      out_status_r <= status_nxt;
      out_rtt_r    <= rtt_nxt;
    end
    if (do_remove) begin
      ans_seq_r[ans_wptr_r] <= req_seq_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_rtt_us          = out_rtt_r;
  // The counter changes only on a commit, so it holds through the result cycle.
  assign out_unmatched_total = unmatched_cnt_r;

endmodule

`default_nettype wire

/* rtl/core/echo_request_reply_matcher_core.sv */
// ----------------------------------------------------------------------------
// echo_request_reply_matcher_core
// Matches echo replies to outstanding requests and reports round-trip time.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                   | Handshake
//  ---------+-----------------------------------------+------------------------
//  input    | in_func, in_seq, in_time_us             | start high, busy low
//  result   | out_status, out_rtt_us,                 | out_valid for one cycle
//           | out_unmatched_total                     |
//
// For each item, the accept cycle compares the sequence number
// against all pending and answered entries in parallel, and the next cycle
// updates the tables and registers the result. busy is high in that update
// cycle only. Reset is synchronous and clears the valid bits, the ring pointer
// and the counter; it needs no clearing pass. The receiver cannot stall; a
// result is shown once while the next item may already be accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module echo_request_reply_matcher_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_func,
  input  wire logic [errm_pkg::SEQ_W-1:0]      in_seq,
  input  wire logic [errm_pkg::TIME_W-1:0]     in_time_us,
  output logic                                 out_valid,
  output logic [errm_pkg::STAT_W-1:0]          out_status,
  output logic [errm_pkg::TIME_W-1:0]          out_rtt_us,
  output logic [errm_pkg::COUNT_W-1:0]         out_unmatched_total
);

  errm_pkg::cmd_t cmd;

  errm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  errm_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_func             (in_func),
    .in_seq              (in_seq),
    .in_time_us          (in_time_us),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_rtt_us          (out_rtt_us),
    .out_unmatched_total (out_unmatched_total)
  );

endmodule

`default_nettype wire
